### design/mcog_pkg.sv
// Shared types for the midpoint circle outline generator.
// Holds the point job passed from the front to the back and the queue status.
// No dependencies.
package mcog_pkg;

  // Number of mirrored pixels emitted for one point.
  localparam int unsigned PixPerPoint = 8;
  localparam int unsigned PixIdxW     = $clog2(PixPerPoint);

  // Work needed to emit the eight pixels of one point.
  typedef struct packed {
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] color;
    logic [15:0] px;
    logic [15:0] py;
    logic        done;
  } mcog_job_t;

  // Status of the point queue between front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } mcog_qstat_t;

endpackage

### design/mcog_front.sv
// Front part: accepts start and step words, keeps the circle state and
// advances the midpoint decision value. Depends on mcog_pkg.
module mcog_front import mcog_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [15:0] in_center_x,
  input  logic [15:0] in_center_y,
  input  logic [10:0] in_radius,
  input  logic [15:0] in_pen_color,
  input  mcog_qstat_t q_stat,
  output logic        push,
  output mcog_job_t   push_job
);

  logic [15:0] cx_r, cy_r, color_r, x_r, y_r, d_r;
  logic        active_r;
  logic [15:0] cx_nxt, cy_nxt, color_nxt, x_nxt, y_nxt, d_nxt;
  logic        active_nxt;

  logic        accept, start;
  logic [15:0] base_x, base_y, base_d;
  logic [15:0] adv_x, adv_y, adv_d;
  logic        adv_done;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign start    = !in_mode;
  assign push     = accept && (start || active_r);

  // Point to emit: a start loads the first point, a step uses the held one.
  always_comb begin
    base_x = start ? 16'd0 : x_r;
    base_y = start ? {5'd0, in_radius} : y_r;
    base_d = start ? (16'd3 - {4'd0, in_radius, 1'b0}) : d_r;
  end

  // Midpoint advance to the next point.
  always_comb begin
    adv_x = base_x + 16'd1;
    if (base_d[15]) begin
      adv_d = base_d + {base_x[13:0], 2'b00} + 16'd6;
      adv_y = base_y;
    end else begin
      adv_d = base_d + {(base_x[13:0] - base_y[13:0]), 2'b00} + 16'd10;
      adv_y = base_y - 16'd1;
    end
    adv_done = $signed(adv_x) > $signed(adv_y);
  end

  // Job for the back part.
  always_comb begin
    push_job.cx    = start ? in_center_x : cx_r;
    push_job.cy    = start ? in_center_y : cy_r;
    push_job.color = start ? in_pen_color : color_r;
    push_job.px    = base_x;
    push_job.py    = base_y;
    push_job.done  = adv_done;
  end

  // Circle state update.
  always_comb begin
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    color_nxt  = color_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    d_nxt      = d_r;
    active_nxt = active_r;
    if (push) begin
      cx_nxt     = push_job.cx;
      cy_nxt     = push_job.cy;
      color_nxt  = push_job.color;
      x_nxt      = adv_x;
      y_nxt      = adv_y;
      d_nxt      = adv_d;
      active_nxt = !adv_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      color_r  <= '0;
      x_r      <= '0;
      y_r      <= '0;
      d_r      <= '0;
      active_r <= 1'b0;
    end else begin
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      color_r  <= color_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      d_r      <= d_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

### design/mcog_queue.sv
// Two-entry point queue between the front and back parts.
// Depends on mcog_pkg.
module mcog_queue import mcog_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  mcog_job_t   push_job,
  input  logic        pop,
  output mcog_job_t   pop_job,
  output mcog_qstat_t q_stat
);

  mcog_job_t   slot_r [2];
  logic        wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;

  assign q_stat.full  = count_r == 2'd2;
  assign q_stat.empty = count_r == 2'd0;
  assign pop_job      = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage for queued points.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### design/mcog_back.sv
// Back part: takes one point job and emits its eight mirrored pixels, one per
// cycle when out_ready allows, via an output register. Depends on mcog_pkg.
module mcog_back import mcog_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  mcog_qstat_t q_stat,
  input  mcog_job_t   head_job,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_pixel_x,
  output logic [15:0] out_pixel_y,
  output logic [15:0] out_pixel_color,
  output logic        out_burst_last,
  output logic        out_circle_done
);

  mcog_job_t          job_r, job_nxt;
  logic               job_valid_r, job_valid_nxt;
  logic [PixIdxW-1:0] k_r, k_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        px_r, py_r, col_r, px_nxt, py_nxt, col_nxt;
  logic               last_r, done_r, last_nxt, done_nxt;

  logic               load, emit, job_end, k_last;
  logic [15:0]        u, v;

  assign load    = !out_valid_r || out_ready;
  assign emit    = load && job_valid_r;
  assign k_last  = k_r == PixIdxW'(PixPerPoint - 1);
  assign job_end = emit && k_last;
  assign pop     = !q_stat.empty && (!job_valid_r || job_end);

  // Mirror selection: bit 2 swaps the axes, bit 0 negates column, bit 1 row.
  always_comb begin
    u = k_r[2] ? job_r.py : job_r.px;
    v = k_r[2] ? job_r.px : job_r.py;
    px_nxt   = k_r[0] ? (job_r.cx - u) : (job_r.cx + u);
    py_nxt   = k_r[1] ? (job_r.cy - v) : (job_r.cy + v);
    col_nxt  = job_r.color;
    last_nxt = k_last;
    done_nxt = k_last && job_r.done;
  end

  // Job holding and pixel counter.
  always_comb begin
    job_nxt       = job_r;
    job_valid_nxt = job_valid_r;
    k_nxt         = k_r;
    if (emit) begin
      k_nxt = k_r + PixIdxW'(1);
    end
    if (job_end) begin
      job_valid_nxt = 1'b0;
    end
    if (pop) begin
      job_nxt       = head_job;
      job_valid_nxt = 1'b1;
      k_nxt         = '0;
    end
    out_valid_nxt = load ? job_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (emit) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      col_r  <= col_nxt;
      last_r <= last_nxt;
      done_r <= done_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = px_r;
  assign out_pixel_y     = py_r;
  assign out_pixel_color = col_r;
  assign out_burst_last  = last_r;
  assign out_circle_done = done_r;

endmodule

### design/midpoint_circle_outline_generator_core.sv
// Top level of the midpoint circle outline generator.
// Instantiates mcog_front, mcog_queue and mcog_back; depends on mcog_pkg.
//
// Channel  Direction  Word contents
// in_      slave      tuser: mode; tdata: center_x, center_y, radius, pen_color
// out_     master     tdata: pixel_x, pixel_y, pixel_color; tlast: burst_last;
//                     tuser: circle_done
//
// A start or step word that draws a point yields eight pixel words, one per
// cycle while out_tready does not stall them; the pixel port sets the pace.
// The first pixel passes the queue slot, back job register and output register.
// Reset clears the circle state, the two-entry point queue and the output.
// in_tready drops only while the point queue holds two points; a stalled
// output holds the back part while the front keeps filling the queue.
module midpoint_circle_outline_generator_core import mcog_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata, low bit up: center_x[15:0], center_y[31:16], radius[42:32],
  // pen_color[58:43], zero fill[63:59].
  input  logic [63:0] in_tdata,
  // in_tuser: mode.
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata, low bit up: pixel_x[15:0], pixel_y[31:16], pixel_color[47:32].
  output logic [47:0] out_tdata,
  output logic        out_tlast,
  // out_tuser: circle_done.
  output logic [0:0]  out_tuser
);

  logic        push, pop;
  mcog_job_t   push_job, head_job;
  mcog_qstat_t q_stat;
  logic [15:0] pix_x, pix_y, pix_col;
  logic        done_flag;

  mcog_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_mode      (in_tuser[0]),
    .in_center_x  (in_tdata[15:0]),
    .in_center_y  (in_tdata[31:16]),
    .in_radius    (in_tdata[42:32]),
    .in_pen_color (in_tdata[58:43]),
    .q_stat       (q_stat),
    .push         (push),
    .push_job     (push_job)
  );

  mcog_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (head_job),
    .q_stat   (q_stat)
  );

  mcog_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .head_job        (head_job),
    .pop             (pop),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_pixel_x     (pix_x),
    .out_pixel_y     (pix_y),
    .out_pixel_color (pix_col),
    .out_burst_last  (out_tlast),
    .out_circle_done (done_flag)
  );

  assign out_tdata    = {pix_col, pix_y, pix_x};
  assign out_tuser[0] = done_flag;

  // The end of a circle only falls on the last pixel of a point.
  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("circle_done without burst_last");

  // The queue never reports full and empty together.
  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");

  // Inside a point the next pixel follows without a gap.
  a_burst_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a pixel burst");

  // The front never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("push into full queue");

endmodule
